/* rtl/core/tcpb_pkg.sv */
package tcpb_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF       = 24;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 30;
  localparam int unsigned THRESH_BITS          = 32;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 32'd256;

  // Region codes on the result
  typedef enum logic [2:0] {
    REG_INSIDE  = 3'd0,
    REG_EDGE_BC = 3'd1,
    REG_EDGE_AC = 3'd2,
    REG_EDGE_AB = 3'd3,
    REG_DEGEN   = 3'd4
  } region_e;

  // How a divider lane's quotient is used
  typedef enum logic [1:0] {
    MODE_DIV  = 2'd0,
    MODE_ZERO = 2'd1,
    MODE_ONE  = 2'd2
  } lane_mode_e;

  typedef struct packed {
    region_e    region;
    lane_mode_e mode_a;
    lane_mode_e mode_b;
  } side_t;

endpackage

/* rtl/core/tcpb_mul.sv */
// Signed W x W multiply, split into half-width partial products.
// Two register stages: partial products, then their sum.
module tcpb_mul #(
  parameter int unsigned W = 52
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int unsigned L = W / 2;
  localparam int unsigned H = W - L;

  logic signed [H-1:0]     ah, bh;
  logic signed [L:0]       al, bl;
  logic signed [2*H-1:0]   hh_q;
  logic signed [H+L:0]     hl_q, lh_q;
  logic signed [2*L+1:0]   ll_q;
  logic signed [2*W-1:0]   sum;

  // Split: signed high half, zero-extended low half
  assign ah = a_i[W-1:L];
  assign bh = b_i[W-1:L];
  assign al = $signed({1'b0, a_i[L-1:0]});
  assign bl = $signed({1'b0, b_i[L-1:0]});

  // Register partial products
  always_ff @(posedge clk_i) begin
    hh_q <= ah * bh;
    hl_q <= ah * bl;
    lh_q <= al * bh;
    ll_q <= al * bl;
  end

  // Align and add
  assign sum = ((2*W)'(hh_q) <<< (2*L))
             + (((2*W)'(hl_q) + (2*W)'(lh_q)) <<< L)
             + (2*W)'(ll_q);

  always_ff @(posedge clk_i) begin
    p_o <= sum;
  end

endmodule

/* rtl/core/tcpb_div.sv */
// Restoring fraction divider: q = floor(n * 2^QW / d) for 0 <= n < d.
// One quotient bit per register stage, QW stages.
module tcpb_div #(
  parameter int unsigned NW = 107,
  parameter int unsigned QW = 30
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic [QW-1:0] q_o
);

  logic [NW-1:0] rem_q [QW];
  logic [NW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in, den_in;
    logic [QW-1:0] quo_in;
    logic [NW:0]   shl;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Shift, compare, subtract
    assign shl = {rem_in, 1'b0};
    assign ge  = shl >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? NW'(shl - {1'b0, den_in}) : NW'(shl);
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[QW-2:0], ge};
    end
  end

  assign q_o = quo_q[QW-1];

endmodule

/* rtl/core/triangle_closest_point_barycentric.sv */
// Closest point on a triangle to the origin, as barycentric weights.
// Throughput: one item per cycle; the dividers take one quotient bit per stage.
// busy is always low and the receiver cannot stall the pipeline.
// Reset clears the valid bits and sets the threshold to 256.
module triangle_closest_point_barycentric #(
  parameter int unsigned COORD_BITS       = tcpb_pkg::COORD_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = tcpb_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [tcpb_pkg::THRESH_BITS-1:0] cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]  ax_i,
  input  logic signed [COORD_BITS-1:0]  ay_i,
  input  logic signed [COORD_BITS-1:0]  az_i,
  input  logic signed [COORD_BITS-1:0]  bx_i,
  input  logic signed [COORD_BITS-1:0]  by_coord_i,
  input  logic signed [COORD_BITS-1:0]  bz_i,
  input  logic signed [COORD_BITS-1:0]  cx_i,
  input  logic signed [COORD_BITS-1:0]  cy_i,
  input  logic signed [COORD_BITS-1:0]  cz_i,
  output logic                          result_valid_o,
  output logic [WEIGHT_FRAC_BITS:0]     weight_a_o,
  output logic [WEIGHT_FRAC_BITS:0]     weight_b_o,
  output logic [WEIGHT_FRAC_BITS:0]     weight_c_o,
  output logic [2:0]                    region_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = CW + 1;
  localparam int unsigned XW = 2 * EW;
  localparam int unsigned DW = 2 * CW + 4;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 3;
  localparam int unsigned WF = WEIGHT_FRAC_BITS;
  localparam logic [WF:0] ONE   = (WF+1)'(1) << WF;
  localparam logic [WF:0] THIRD = ONE / 3;

  typedef struct packed {
    logic signed [DW-1:0] d00;
    logic signed [DW-1:0] d11;
    logic signed [DW-1:0] d20;
    logic signed [DW-1:0] d21;
    logic signed [DW-1:0] n1;
    logic signed [DW-1:0] den1;
  } edge_t;

  logic [tcpb_pkg::THRESH_BITS-1:0] thr_q;
  logic [7:0] vld_q;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tcpb_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Stage 1: vertices and edge vectors
  logic signed [CW-1:0] a_q [3], b_q [3];
  logic signed [EW-1:0] e0_q [3], e1_q [3], e12_q [3];
  logic signed [CW-1:0] ain [3], bin [3], cin [3];

  assign ain[0] = ax_i; assign ain[1] = ay_i;       assign ain[2] = az_i;
  assign bin[0] = bx_i; assign bin[1] = by_coord_i; assign bin[2] = bz_i;
  assign cin[0] = cx_i; assign cin[1] = cy_i;       assign cin[2] = cz_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_q[i]   <= ain[i];
      b_q[i]   <= bin[i];
      e0_q[i]  <= EW'(bin[i]) - EW'(ain[i]);
      e1_q[i]  <= EW'(cin[i]) - EW'(ain[i]);
      e12_q[i] <= EW'(cin[i]) - EW'(bin[i]);
    end
  end

  // Stage 2: component products
  logic signed [XW-1:0] p00_q [3], p01_q [3], p11_q [3], p20_q [3];
  logic signed [XW-1:0] p21_q [3], pbe_q [3], pee_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p00_q[i] <= e0_q[i] * e0_q[i];
      p01_q[i] <= e0_q[i] * e1_q[i];
      p11_q[i] <= e1_q[i] * e1_q[i];
      p20_q[i] <= EW'(a_q[i]) * e0_q[i];
      p21_q[i] <= EW'(a_q[i]) * e1_q[i];
      pbe_q[i] <= EW'(b_q[i]) * e12_q[i];
      pee_q[i] <= e12_q[i] * e12_q[i];
    end
  end

  // Stage 3: dot products
  logic signed [DW-1:0] d01_q;
  edge_t edge3_q;

  always_ff @(posedge clk_i) begin
    d01_q        <= DW'(p01_q[0]) + DW'(p01_q[1]) + DW'(p01_q[2]);
    edge3_q.d00  <= DW'(p00_q[0]) + DW'(p00_q[1]) + DW'(p00_q[2]);
    edge3_q.d11  <= DW'(p11_q[0]) + DW'(p11_q[1]) + DW'(p11_q[2]);
    edge3_q.d20  <= -(DW'(p20_q[0]) + DW'(p20_q[1]) + DW'(p20_q[2]));
    edge3_q.d21  <= -(DW'(p21_q[0]) + DW'(p21_q[1]) + DW'(p21_q[2]));
    edge3_q.n1   <= -(DW'(pbe_q[0]) + DW'(pbe_q[1]) + DW'(pbe_q[2]));
    edge3_q.den1 <= DW'(pee_q[0]) + DW'(pee_q[1]) + DW'(pee_q[2]);
  end

  // Stages 4-5: the six wide products
  logic signed [PW-1:0] m_s [6];
  logic signed [DW-1:0] ma [6], mb [6];

  assign ma[0] = edge3_q.d00; assign mb[0] = edge3_q.d11;
  assign ma[1] = d01_q;       assign mb[1] = d01_q;
  assign ma[2] = edge3_q.d11; assign mb[2] = edge3_q.d20;
  assign ma[3] = d01_q;       assign mb[3] = edge3_q.d21;
  assign ma[4] = edge3_q.d00; assign mb[4] = edge3_q.d21;
  assign ma[5] = d01_q;       assign mb[5] = edge3_q.d20;

  for (genvar m = 0; m < 6; m++) begin : g_mul
    tcpb_mul #(.W(DW)) u_mul (
      .clk_i (clk_i),
      .a_i   (ma[m]),
      .b_i   (mb[m]),
      .p_o   (m_s[m])
    );
  end

  // Carry the edge terms alongside (stages 4 to 7)
  edge_t edge_q [4];

  always_ff @(posedge clk_i) begin
    edge_q[0] <= edge3_q;
    for (int k = 1; k < 4; k++) edge_q[k] <= edge_q[k-1];
  end

  // Stage 6: determinant and numerators
  logic signed [NW-1:0] denom6_q, nu6_q, nv6_q;

  always_ff @(posedge clk_i) begin
    denom6_q <= NW'(m_s[0]) - NW'(m_s[1]);
    nu6_q    <= NW'(m_s[2]) - NW'(m_s[3]);
    nv6_q    <= NW'(m_s[4]) - NW'(m_s[5]);
  end

  // Stage 7: third numerator and degenerate test
  logic signed [NW-1:0] denom7_q, nu7_q, nv7_q;
  logic                 nw_neg7_q, degen7_q;
  logic signed [NW-1:0] nw6;
  logic [NW-1:0]        abs6;

  assign nw6  = denom6_q - nu6_q - nv6_q;
  assign abs6 = denom6_q[NW-1] ? NW'(-denom6_q) : NW'(denom6_q);

  always_ff @(posedge clk_i) begin
    denom7_q  <= denom6_q;
    nu7_q     <= nu6_q;
    nv7_q     <= nv6_q;
    nw_neg7_q <= nw6[NW-1];
    degen7_q  <= (denom6_q == '0) || (abs6 < NW'(thr_q));
  end

  // Stage 8: pick region and divider operands, clamp where possible
  function automatic tcpb_pkg::lane_mode_e clamp_mode(logic signed [NW-1:0] n,
                                                      logic signed [NW-1:0] d);
    tcpb_pkg::lane_mode_e r;
    if (d <= 0 || n <= 0) r = tcpb_pkg::MODE_ZERO;
    else if (n >= d)      r = tcpb_pkg::MODE_ONE;
    else                  r = tcpb_pkg::MODE_DIV;
    return r;
  endfunction

  logic signed [NW-1:0] na, da;
  tcpb_pkg::side_t      side8;
  logic [NW-1:0]        num_a_q, den_a_q, num_b_q, den_b_q;
  tcpb_pkg::side_t      side8_q;

  always_comb begin
    na = denom7_q;
    da = denom7_q;
    side8.region = tcpb_pkg::REG_DEGEN;
    if (degen7_q) begin
      side8.region = tcpb_pkg::REG_DEGEN;
    end else if (nw_neg7_q) begin
      side8.region = tcpb_pkg::REG_EDGE_BC;
      na = NW'(edge_q[3].n1);
      da = NW'(edge_q[3].den1);
    end else if (nu7_q[NW-1]) begin
      side8.region = tcpb_pkg::REG_EDGE_AC;
      na = NW'(edge_q[3].d21);
      da = NW'(edge_q[3].d11);
    end else if (nv7_q[NW-1]) begin
      side8.region = tcpb_pkg::REG_EDGE_AB;
      na = NW'(edge_q[3].d20);
      da = NW'(edge_q[3].d00);
    end else begin
      side8.region = tcpb_pkg::REG_INSIDE;
      na = nu7_q;
    end
    side8.mode_a = degen7_q ? tcpb_pkg::MODE_ZERO : clamp_mode(na, da);
    side8.mode_b = (side8.region == tcpb_pkg::REG_INSIDE) ?
                   clamp_mode(nv7_q, denom7_q) : tcpb_pkg::MODE_ZERO;
  end

  always_ff @(posedge clk_i) begin
    side8_q <= side8;
    // Feed 0/1 where the quotient is not used
    if (side8.mode_a == tcpb_pkg::MODE_DIV) begin
      num_a_q <= na;
      den_a_q <= da;
    end else begin
      num_a_q <= '0;
      den_a_q <= NW'(1);
    end
    if (side8.mode_b == tcpb_pkg::MODE_DIV) begin
      num_b_q <= nv7_q;
      den_b_q <= denom7_q;
    end else begin
      num_b_q <= '0;
      den_b_q <= NW'(1);
    end
  end

  // Dividers
  logic [WF-1:0] q_a, q_b;

  tcpb_div #(.NW(NW), .QW(WF)) u_div_a (
    .clk_i (clk_i),
    .num_i (num_a_q),
    .den_i (den_a_q),
    .q_o   (q_a)
  );

  tcpb_div #(.NW(NW), .QW(WF)) u_div_b (
    .clk_i (clk_i),
    .num_i (num_b_q),
    .den_i (den_b_q),
    .q_o   (q_b)
  );

  // Side information alongside the dividers
  tcpb_pkg::side_t side_q [WF];
  logic [WF-1:0]   vd_q;

  always_ff @(posedge clk_i) begin
    side_q[0] <= side8_q;
    for (int k = 1; k < WF; k++) side_q[k] <= side_q[k-1];
  end

  // Valid bits through the whole pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      vd_q           <= '0;
      result_valid_o <= 1'b0;
    end else begin
      vld_q          <= {vld_q[6:0], start && !busy};
      vd_q           <= {vd_q[WF-2:0], vld_q[7]};
      result_valid_o <= vd_q[WF-1];
    end
  end

  // Final: compose the weights
  tcpb_pkg::side_t sf;
  logic [WF:0]     ta, tb;
  logic [WF+1:0]   tsum;
  logic [WF:0]     wa, wb, wc;

  assign sf = side_q[WF-1];

  always_comb begin
    case (sf.mode_a)
      tcpb_pkg::MODE_ONE:  ta = ONE;
      tcpb_pkg::MODE_DIV:  ta = {1'b0, q_a};
      default:             ta = '0;
    endcase
    case (sf.mode_b)
      tcpb_pkg::MODE_ONE:  tb = ONE;
      tcpb_pkg::MODE_DIV:  tb = {1'b0, q_b};
      default:             tb = '0;
    endcase
    tsum = (WF+2)'(ta) + (WF+2)'(tb);
    case (sf.region)
      tcpb_pkg::REG_INSIDE: begin
        wb = ta;
        wc = tb;
        wa = (tsum >= (WF+2)'(ONE)) ? '0 : (WF+1)'((WF+2)'(ONE) - tsum);
      end
      tcpb_pkg::REG_EDGE_BC: begin
        wa = '0;
        wb = ONE - ta;
        wc = ta;
      end
      tcpb_pkg::REG_EDGE_AC: begin
        wa = ONE - ta;
        wb = '0;
        wc = ta;
      end
      tcpb_pkg::REG_EDGE_AB: begin
        wa = ONE - ta;
        wb = ta;
        wc = '0;
      end
      default: begin
        wa = THIRD;
        wb = THIRD;
        wc = THIRD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    weight_a_o <= wa;
    weight_b_o <= wb;
    weight_c_o <= wc;
    region_o   <= sf.region;
  end

endmodule
